// File: rtl/itoa_pkg.sv
package itoa_pkg;

    localparam int C_BASE_W = 6;
    localparam int C_CHAR_W = 7;

    localparam logic [C_BASE_W-1:0] C_BASE_MIN   = 6'd2;
    localparam logic [C_BASE_W-1:0] C_BASE_MAX   = 6'd36;
    localparam logic [C_BASE_W-1:0] C_BASE_DEC   = 6'd10;
    localparam logic [C_BASE_W-1:0] C_MAX_DEC_DIGIT = 6'd9;

    localparam logic [C_CHAR_W-1:0] C_ASCII_ZERO  = 7'h30;
    localparam logic [C_CHAR_W-1:0] C_ASCII_A     = 7'h61;
    localparam logic [C_CHAR_W-1:0] C_ASCII_MINUS = 7'h2D;

    typedef logic [C_BASE_W-1:0] t_base;
    typedef logic [C_CHAR_W-1:0] t_char;

    function automatic t_base eff_base(input t_base b);
        t_base r;
        if (b < C_BASE_MIN) begin
            r = C_BASE_MIN;
        end else if (b > C_BASE_MAX) begin
            r = C_BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic t_char digit_to_ascii(input t_base d);
        t_char r;
        if (d > C_MAX_DEC_DIGIT) begin
            r = C_CHAR_W'(d - C_BASE_DEC) + C_ASCII_A;
        end else begin
            r = C_CHAR_W'(d) + C_ASCII_ZERO;
        end
        return r;
    endfunction

endpackage

// File: rtl/itoa_div.sv
module itoa_div #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  itoa_pkg::t_base        i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quot,
    output itoa_pkg::t_base        o_rem
);
    import itoa_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_q;
    logic [VALUE_WIDTH-1:0] n_q;
    t_base                  r_rem;
    t_base                  n_rem;
    t_base                  r_div;
    logic [CW-1:0]          r_cnt;
    logic                   r_done;
    logic [C_BASE_W:0]      w_sh;
    logic [C_BASE_W:0]      w_diff;
    logic                   w_ge;

    always_comb begin
        w_sh   = {r_rem, r_q[VALUE_WIDTH-1]};
        w_ge   = w_sh >= {1'b0, r_div};
        w_diff = w_sh - {1'b0, r_div};
        n_rem  = w_ge ? w_diff[C_BASE_W-1:0] : w_sh[C_BASE_W-1:0];
        n_q    = {r_q[VALUE_WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(VALUE_WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: rtl/integer_to_ascii_radix.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_value
// out       output     o_out_valid / i_out_ready   o_out_char, o_last_char
// cfg       input      i_cfg_we                    i_cfg_data (base, 2 to 36)
//
// Each digit is one division on the shared restoring divider, and the digits of an
// item are found one after another; a leading minus and any cycles the output is
// stalled add to the time an item takes.
// Reset is synchronous, active low; the base resets to 10.
// New items are taken only between conversions; one output register holds a char.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output itoa_pkg::t_char               o_out_char,
    output logic                          o_last_char,
    input  logic                          i_cfg_we,
    input  itoa_pkg::t_base               i_cfg_data
);
    import itoa_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int IW = $clog2(VALUE_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_MINUS = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                 r_state;
    t_base                  r_base_radix;
    t_base                  r_base;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    t_base                  r_store [VALUE_WIDTH];
    logic                   r_out_valid;
    t_char                  r_out_char;
    logic                   r_last;

    logic                   w_accept;
    logic                   w_slot_free;
    logic                   w_emit;
    t_base                  w_eff;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [CW-1:0]          w_rd_cnt;
    logic [IW-1:0]          w_rd_idx;
    logic                   w_div_start;
    logic [VALUE_WIDTH-1:0] w_div_dividend;
    t_base                  w_div_divisor;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_div_quot;
    t_base                  w_div_rem;
    logic                   w_more;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_emit      = ((r_state == S_MINUS) || (r_state == S_EMIT)) && w_slot_free;
    assign w_more      = (r_state == S_DIV) && w_div_done && (w_div_quot != '0);
    assign w_rd_cnt    = r_cnt - 1'b1;
    assign w_rd_idx    = w_rd_cnt[IW-1:0];

    always_comb begin
        w_eff = eff_base(r_base_radix);
        w_neg = (w_eff == C_BASE_DEC) && i_value[VALUE_WIDTH-1];
        if (w_neg) begin
            w_mag = ~$unsigned(i_value) + VALUE_WIDTH'(1);
        end else begin
            w_mag = $unsigned(i_value);
        end
        w_div_start    = w_accept || w_more;
        w_div_dividend = w_accept ? w_mag : w_div_quot;
        w_div_divisor  = w_accept ? w_eff : r_base;
    end

    itoa_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_radix <= C_BASE_DEC;
        end else if (i_cfg_we) begin
            r_base_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_neg   <= w_neg;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_div_quot == '0) begin
                            r_state <= r_neg ? S_MINUS : S_EMIT;
                        end
                    end
                end
                S_MINUS: begin
                    if (w_slot_free) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_cnt <= w_rd_cnt;
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_eff;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_store[r_cnt[IW-1:0]] <= w_div_rem;
        end
        if ((r_state == S_MINUS) && w_slot_free) begin
            r_out_char <= C_ASCII_MINUS;
            r_last     <= 1'b0;
        end else if ((r_state == S_EMIT) && w_slot_free) begin
            r_out_char <= digit_to_ascii(r_store[w_rd_idx]);
            r_last     <= (r_cnt == CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last;

endmodule

// File: sim/tb_integer_to_ascii_radix.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix;
    import itoa_pkg::*;

    localparam int VALUE_WIDTH = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef logic signed [VALUE_WIDTH-1:0] t_sval;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_char_result;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_sval  i_value = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_char  o_out_char;
    logic   o_last_char;
    logic   i_cfg_we = 1'b0;
    t_base  i_cfg_data = '0;

    t_char_result pending_chars[$];
    t_sval        stim_values[$];
    t_base        base_reg = C_BASE_DEC;
    int           char_errors = 0;
    int           burst_left = 0;
    bit           idle_en = 1'b1;
    int           hold_request = 0;
    int           hold_left = 0;
    int           rx_mode = 0;
    int           rx_span = 0;
    int           rx_phase = 0;
    int           idle_cycles = 0;

    integer_to_ascii_radix #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_char (o_out_char),
        .o_last_char(o_last_char),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predict_digits(input t_sval v);
        t_base        b;
        t_base        d;
        logic [16:0]  mag;
        t_base        digs[16];
        int           n;
        bit           neg;
        t_char_result r;
        b = base_reg;
        if (b < C_BASE_MIN) begin
            b = C_BASE_MIN;
        end else if (b > C_BASE_MAX) begin
            b = C_BASE_MAX;
        end
        neg = (b == C_BASE_DEC) && v[VALUE_WIDTH-1];
        mag = neg ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        n = 0;
        if (mag == 0) begin
            digs[0] = '0;
            n = 1;
        end
        while (mag != 0) begin
            digs[n] = t_base'(mag % b);
            mag = mag / b;
            n++;
        end
        if (neg) begin
            r.ch = C_ASCII_MINUS;
            r.last = 1'b0;
            pending_chars.push_back(r);
        end
        for (int k = n - 1; k >= 0; k--) begin
            d = digs[k];
            r.ch = (d > C_MAX_DEC_DIGIT) ? t_char'(d - C_BASE_DEC) + C_ASCII_A
                                         : t_char'(d) + C_ASCII_ZERO;
            r.last = (k == 0);
            pending_chars.push_back(r);
        end
    endfunction

    function automatic void check_char(input t_char ch, input logic last);
        t_char_result want;
        if (pending_chars.size() == 0) begin
            char_errors++;
            if (char_errors <= 10) begin
                $display("ERROR: unexpected char 0x%02h last %b", ch, last);
            end
        end else begin
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                char_errors++;
                if (char_errors <= 10) begin
                    $display("ERROR: char expected 0x%02h last %b, got 0x%02h last %b",
                             want.ch, want.last, ch, last);
                end
            end
        end
    endfunction

    function automatic t_sval rand_value();
        t_sval r;
        case ($urandom_range(0, 3))
            0: r = t_sval'($urandom_range(0, 80)) - t_sval'(40);
            1: begin
                case ($urandom_range(0, 3))
                    0: r = '0;
                    1: r = '1;
                    2: r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    default: r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                endcase
            end
            default: r = t_sval'($urandom);
        endcase
        return r;
    endfunction

    // receiver: check accepted items, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            check_char(o_out_char, o_last_char);
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(20, 120);
        end else begin
            rx_span--;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!idle_en) begin
            i_out_ready <= 1'b1;
        end else begin
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: i_out_ready <= ((rx_phase % 4) == 0);
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1)
            || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_sval v, input bit more);
        i_in_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_digits(v);
        if (!more) begin
            i_in_valid <= 1'b0;
        end else if (idle_en && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 7);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drive_values();
        t_sval v;
        while (stim_values.size() > 0) begin
            v = stim_values.pop_front();
            send_item(v, stim_values.size() > 0);
        end
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_base(input t_base b);
        wait_drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_reg = b;
    endtask

    task automatic test_reset_base();
        stim_values = '{t_sval'(0), t_sval'(1), t_sval'(-1), t_sval'(9), t_sval'(10),
                        t_sval'(32767), t_sval'(-32768), t_sval'(-10), t_sval'(12345),
                        t_sval'(-9999)};
        drive_values();
    endtask

    task automatic test_base_limits();
        set_base(C_BASE_MIN);
        stim_values = '{t_sval'(0), t_sval'(-1), t_sval'(-32768), t_sval'(32767)};
        drive_values();
        set_base(C_BASE_MAX);
        stim_values = '{t_sval'(35), t_sval'(36), t_sval'(-1), t_sval'(32767)};
        drive_values();
        set_base(6'd16);
        stim_values = '{t_sval'(-1), t_sval'(16'habcd)};
        drive_values();
        set_base(6'd0);
        stim_values = '{t_sval'(5)};
        drive_values();
        set_base(6'd1);
        stim_values = '{t_sval'(6)};
        drive_values();
        set_base(6'd63);
        stim_values = '{t_sval'(35)};
        drive_values();
        set_base(6'd37);
        stim_values = '{t_sval'(36)};
        drive_values();
    endtask

    task automatic test_random_values();
        t_base b;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: b = C_BASE_DEC;
                1: b = C_BASE_MIN;
                2: b = C_BASE_MAX;
                default: b = t_base'($urandom_range(0, 63));
            endcase
            set_base(b);
            for (int i = 0; i < 10; i++) begin
                stim_values.push_back(rand_value());
            end
            drive_values();
        end
    endtask

    task automatic test_output_hold();
        set_base(C_BASE_MIN);
        idle_en = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 10; i++) begin
            stim_values.push_back(rand_value());
        end
        drive_values();
        wait_drain();
        idle_en = 1'b1;
    endtask

    task automatic test_streaming();
        set_base(C_BASE_DEC);
        idle_en = 1'b0;
        for (int i = 0; i < 12; i++) begin
            stim_values.push_back(rand_value());
        end
        drive_values();
        wait_drain();
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_base();
        test_base_limits();
        test_random_values();
        test_output_hold();
        test_streaming();
        wait_drain();
        repeat (400) @(posedge i_clk);
        if (char_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/itoa_pkg.sv
rtl/itoa_div.sv
rtl/integer_to_ascii_radix.sv
sim/tb_integer_to_ascii_radix.sv
